@@ hw/rtl/bsl_pkg.sv @@
// ----------------------------------------------------------------------------
// bsl_pkg
// Types and codes shared by the bounded sequential list and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package bsl_pkg;

  localparam int BSL_CAPACITY = 8;

  // request codes
  localparam logic [2:0] REQ_INS_FRONT = 3'd0;
  localparam logic [2:0] REQ_INS_BACK  = 3'd1;
  localparam logic [2:0] REQ_SEARCH    = 3'd2;
  localparam logic [2:0] REQ_DEL_FRONT = 3'd3;
  localparam logic [2:0] REQ_DEL_BACK  = 3'd4;
  localparam logic [2:0] REQ_DEL_KEY   = 3'd5;

  // status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_MISS  = 2'd3;

  localparam logic [3:0] IDX_NONE = 4'hF;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] key;
  } bsl_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic signed [3:0] index;
    logic [3:0]        count;
  } bsl_out_t;

  // command broadcast from the sequencer to every cell
  typedef enum logic [2:0] {
    OP_IDLE,
    OP_MATCH,
    OP_WAVE,
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_PULL_FRONT,
    OP_PULL_KEY
  } cell_op_t;

endpackage

`default_nettype wire

@@ hw/rtl/bounded_sequential_list_unit.sv @@
// ----------------------------------------------------------------------------
// bounded_sequential_list_unit
// Ordered list of up to CAPACITY signed keys kept in a row of slot cells.
// ----------------------------------------------------------------------------
// A request (in_req: req_type, key) is taken at a clock edge with start high
// and busy low. Each request gives exactly one result on out_res (status,
// index, count after the request), shown for one cycle with out_valid high.
// The receiver cannot stall; results must be taken when shown.
// Insert front/back, delete front/back and unused codes: the request goes to
// S_DONE, where the result is registered; busy is high for one cycle, so a
// new request cannot be taken until busy is low again.
// Search and delete by key: the slots first compare against the key, then a
// first-match wavefront ripples one slot per cycle through the row of
// CAPACITY cells; the result is registered in S_DONE after the wave, and busy
// stays high through S_MATCH, S_WAVE and S_DONE.
// A new request may be taken in the same cycle a result is shown.
// Reset (rst_n low, synchronous) empties the list and drops any request in
// flight; no result is shown for it.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_sequential_list_unit import bsl_pkg::*; #(
  parameter int CAPACITY = BSL_CAPACITY
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  output logic         busy,
  input  wire bsl_in_t in_req,
  output logic         out_valid,
  output bsl_out_t     out_res
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef enum logic [1:0] {S_IDLE, S_MATCH, S_WAVE, S_DONE} state_t;

  state_t             state_r, state_nxt;
  logic [2:0]         req_r, req_nxt;
  logic signed [31:0] key_r, key_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   wave_r, wave_nxt;
  logic               out_valid_r, out_valid_nxt;
  bsl_out_t           out_res_r, out_res_nxt;

  cell_op_t           op;
  cell_op_t           apply_op;
  logic [CNT_W-1:0]   new_cnt;
  logic [1:0]         res_status;
  logic [3:0]         res_index;
  logic               full;
  logic               empty;
  logic               found;
  logic [IDX_W-1:0]   found_idx;

  logic signed [31:0] data_w [CAPACITY];
  logic               f_w    [CAPACITY];
  logic [IDX_W-1:0]   fi_w   [CAPACITY];

  // row of slot cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] lo_d;
    logic signed [31:0] hi_d;
    logic               f_i;
    logic [IDX_W-1:0]   fi_i;

    if (i == 0) begin : g_first
      assign lo_d = key_r;
      assign f_i  = 1'b0;
      assign fi_i = '0;
    end else begin : g_mid
      assign lo_d = data_w[i-1];
      assign f_i  = f_w[i-1];
      assign fi_i = fi_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign hi_d = data_w[i];
    end else begin : g_upper
      assign hi_d = data_w[i+1];
    end

    bsl_cell #(
      .CNT_W (CNT_W),
      .IDX_W (IDX_W),
      .IDX   (i)
    ) u_cell (
      .clk     (clk),
      .op      (op),
      .count   (cnt_r),
      .key     (key_r),
      .lo_data (lo_d),
      .hi_data (hi_d),
      .f_in    (f_i),
      .fi_in   (fi_i),
      .data    (data_w[i]),
      .f_out   (f_w[i]),
      .fi_out  (fi_w[i])
    );
  end

  assign full      = cnt_r == CNT_W'(CAPACITY);
  assign empty     = cnt_r == '0;
  assign found     = f_w[CAPACITY-1];
  assign found_idx = fi_w[CAPACITY-1];

  // outcome of the request held in req_r, used in S_DONE
  always_comb begin
    apply_op   = OP_IDLE;
    new_cnt    = cnt_r;
    res_status = ST_DONE;
    res_index  = IDX_NONE;
    case (req_r)
      REQ_INS_FRONT, REQ_INS_BACK: begin
        if (full) begin
          res_status = ST_FULL;
        end else begin
          apply_op  = (req_r == REQ_INS_FRONT) ? OP_PUSH_FRONT : OP_PUSH_BACK;
          new_cnt   = cnt_r + 1'b1;
          res_index = (req_r == REQ_INS_FRONT) ? 4'd0 : 4'(cnt_r);
        end
      end
      REQ_SEARCH: begin
        if (found) begin
          res_index = 4'(found_idx);
        end else begin
          res_status = ST_MISS;
        end
      end
      REQ_DEL_FRONT, REQ_DEL_BACK: begin
        if (empty) begin
          res_status = ST_EMPTY;
        end else begin
          apply_op  = (req_r == REQ_DEL_FRONT) ? OP_PULL_FRONT : OP_IDLE;
          new_cnt   = cnt_r - 1'b1;
          res_index = (req_r == REQ_DEL_FRONT) ? 4'd0 : 4'(cnt_r - 1'b1);
        end
      end
      REQ_DEL_KEY: begin
        if (empty) begin
          res_status = ST_EMPTY;
        end else if (found) begin
          apply_op  = OP_PULL_KEY;
          new_cnt   = cnt_r - 1'b1;
          res_index = 4'(found_idx);
        end else begin
          res_status = ST_MISS;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    case (state_r)
      S_MATCH: op = OP_MATCH;
      S_WAVE:  op = OP_WAVE;
      S_DONE:  op = apply_op;
      default: op = OP_IDLE;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    key_nxt       = key_r;
    cnt_nxt       = cnt_r;
    wave_nxt      = wave_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt = in_req.req_type;
          key_nxt = in_req.key;
          if (in_req.req_type == REQ_SEARCH || in_req.req_type == REQ_DEL_KEY) begin
            state_nxt = S_MATCH;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_MATCH: begin
        wave_nxt  = '0;
        state_nxt = S_WAVE;
      end
      S_WAVE: begin
        // one slot per cycle until the front has crossed the whole row
        if (wave_r == CNT_W'(CAPACITY - 1)) begin
          state_nxt = S_DONE;
        end else begin
          wave_nxt = wave_r + 1'b1;
        end
      end
      S_DONE: begin
        cnt_nxt             = new_cnt;
        out_valid_nxt       = 1'b1;
        out_res_nxt.status  = res_status;
        out_res_nxt.index   = res_index;
        out_res_nxt.count   = 4'(new_cnt);
        state_nxt           = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      wave_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      wave_r      <= wave_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r     <= req_nxt;
    key_r     <= key_nxt;
    out_res_r <= out_res_nxt;
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

`default_nettype wire

@@ hw/rtl/bsl_cell.sv @@
// ----------------------------------------------------------------------------
// bsl_cell
// One list slot: holds an entry, compares it with the key and passes the
// first-match wavefront on to the next slot.
// ----------------------------------------------------------------------------
`default_nettype none

module bsl_cell import bsl_pkg::*; #(
  parameter int CNT_W = 4,
  parameter int IDX_W = 3,
  parameter int IDX   = 0
) (
  input  wire logic               clk,
  input  wire cell_op_t           op,
  input  wire logic [CNT_W-1:0]   count,
  input  wire logic signed [31:0] key,
  input  wire logic signed [31:0] lo_data,
  input  wire logic signed [31:0] hi_data,
  input  wire logic               f_in,
  input  wire logic [IDX_W-1:0]   fi_in,
  output logic signed [31:0]      data,
  output logic                    f_out,
  output logic [IDX_W-1:0]        fi_out
);

  logic signed [31:0] data_r;
  logic               m_r;
  logic               f_r;
  logic [IDX_W-1:0]   fi_r;
  logic               occupied;
  logic               at_count;

  assign occupied = CNT_W'(IDX) < count;
  assign at_count = CNT_W'(IDX) == count;

  always_ff @(posedge clk) begin
    case (op)
      OP_MATCH: begin
        m_r <= occupied && (data_r == key);
        f_r <= 1'b0;
      end
      OP_WAVE: begin
        // f_r ends up as "a match sits at or below this slot"
        f_r  <= f_in | m_r;
        fi_r <= f_in ? fi_in : IDX_W'(IDX);
      end
      OP_PUSH_FRONT: data_r <= lo_data;
      OP_PUSH_BACK: begin
        if (at_count) begin
          data_r <= key;
        end
      end
      OP_PULL_FRONT: data_r <= hi_data;
      OP_PULL_KEY: begin
        if (f_r) begin
          data_r <= hi_data;
        end
      end
      default: ;
    endcase
  end

  assign data   = data_r;
  assign f_out  = f_r;
  assign fi_out = fi_r;

endmodule

`default_nettype wire
